// File: design/cpot_pkg.sv
// shared types and constants for the collider pair overlap test
// no dependencies
`default_nettype none
package cpot_pkg;
  localparam int unsigned VEC_BITS = 63;
  localparam int unsigned RAD_BITS = 20;
  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_BOX    = 1'b1;

  typedef enum logic [1:0] {
    TEST_SS = 2'd0,
    TEST_BB = 2'd1,
    TEST_BS = 2'd2
  } test_e;
endpackage
`default_nettype wire

// File: design/cpot_front.sv
// front stage: unpacks a pair, forms centers and scaled extents, selects the test
// depends on cpot_pkg
`default_nettype none
module cpot_front import cpot_pkg::*; #(
  parameter int unsigned CB = 21,
  parameter int unsigned FB = 8,
  parameter int unsigned CW = CB + 1 + FB,
  parameter int unsigned HW = 2 * CB + 1,
  parameter int unsigned RW = RAD_BITS + CB
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2*(4*VEC_BITS+RAD_BITS+1)-1:0] in_data_i,
  output logic                     f_valid_o,
  input  wire logic                f_ready_i,
  output test_e                    f_test_o,
  output logic signed [CW-1:0]     f_box_c_o [3],
  output logic signed [HW-1:0]     f_box_h_o [3],
  output logic signed [CW-1:0]     f_oth_c_o [3],
  output logic signed [HW-1:0]     f_oth_h_o [3],
  output logic [RW-1:0]            f_r0_o,
  output logic [RW-1:0]            f_r1_o
);
  localparam int unsigned BW = 4 * VEC_BITS + RAD_BITS + 1;

  logic signed [CW-1:0] c_d [2][3];
  logic signed [HW-1:0] h_d [2][3];
  logic [RW-1:0] r_d [2];
  logic [1:0] kind;
  test_e test_d;
  logic valid_q;

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      logic [BW-1:0] f;
      logic [CB-1:0] mx;
      logic signed [CB-1:0] p, o, s, hs;
      logic [CB-1:0] m;
      f = in_data_i[b*BW +: BW];
      kind[b] = f[0];
      mx = '0;
      for (int i = 0; i < 3; i++) begin
        p  = f[1 + i*CB +: CB];
        o  = f[1 + VEC_BITS + i*CB +: CB];
        s  = f[1 + 2*VEC_BITS + i*CB +: CB];
        hs = f[1 + 3*VEC_BITS + i*CB +: CB];
        m  = s[CB-1] ? CB'(-s) : CB'(s);
        c_d[b][i] = CW'((CW'(p) + CW'(o)) <<< FB);
        h_d[b][i] = HW'(hs) * $signed({1'b0, m});
        if (m > mx) mx = m;
      end
      r_d[b] = RW'(f[1 + 4*VEC_BITS +: RAD_BITS]) * RW'(mx);
    end
    if (kind == 2'b00) test_d = TEST_SS;
    else if (kind == 2'b11) test_d = TEST_BB;
    else test_d = TEST_BS;
  end

  assign in_ready_o = !valid_q || f_ready_i;
  assign f_valid_o  = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (in_ready_o) valid_q <= in_valid_i;
  end

  // box role goes to whichever side is a box
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      logic sw;
      sw = (kind == 2'b10);
      f_test_o <= test_d;
      for (int i = 0; i < 3; i++) begin
        f_box_c_o[i] <= sw ? c_d[1][i] : c_d[0][i];
        f_box_h_o[i] <= sw ? h_d[1][i] : h_d[0][i];
        f_oth_c_o[i] <= sw ? c_d[0][i] : c_d[1][i];
        f_oth_h_o[i] <= sw ? h_d[0][i] : h_d[1][i];
      end
      f_r0_o <= sw ? r_d[1] : r_d[0];
      f_r1_o <= sw ? r_d[0] : r_d[1];
    end
  end
endmodule
`default_nettype wire

// File: design/cpot_queue.sv
// two-entry queue between front and back stages
// depends on cpot_pkg
`default_nettype none
module cpot_queue import cpot_pkg::*; #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_valid_i,
  output logic              s_ready_o,
  input  wire logic [W-1:0] s_data_i,
  output logic              m_valid_o,
  input  wire logic         m_ready_i,
  output logic [W-1:0]      m_data_o
);
  logic [W-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign s_ready_o = cnt_q != 2'd2;
  assign m_valid_o = cnt_q != 2'd0;
  assign m_data_o  = mem_q[rp_q];
  assign push = s_valid_i && s_ready_o;
  assign pop  = m_valid_o && m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= s_data_i;
  end
endmodule
`default_nettype wire

// File: design/cpot_back.sv
// back stage: differences and clamp, partial products, squares, then sums and compare
// depends on cpot_pkg
`default_nettype none
module cpot_back import cpot_pkg::*; #(
  parameter int unsigned CB = 21,
  parameter int unsigned FB = 8,
  parameter int unsigned CW = CB + 1 + FB,
  parameter int unsigned HW = 2 * CB + 1,
  parameter int unsigned RW = RAD_BITS + CB
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  test_e                 s_test_i,
  input  wire logic signed [CW-1:0] s_box_c_i [3],
  input  wire logic signed [HW-1:0] s_box_h_i [3],
  input  wire logic signed [CW-1:0] s_oth_c_i [3],
  input  wire logic signed [HW-1:0] s_oth_h_i [3],
  input  wire logic [RW-1:0]    s_r0_i,
  input  wire logic [RW-1:0]    s_r1_i,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output logic                  m_overlap_o
);
  localparam int unsigned DW = (CW > HW ? CW : HW) + 2;
  localparam int unsigned MW = (DW > RW + 1) ? DW : RW + 1;
  localparam int unsigned LW = (MW + 1) / 2;
  localparam int unsigned UW = MW - LW;
  localparam int unsigned PLW = 2 * LW;
  localparam int unsigned PUW = 2 * UW;
  localparam int unsigned SW = 2 * MW + 2;

  // stage 1: per-axis magnitudes
  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;
  test_e t1_q, t2_q, t3_q;
  logic [MW-1:0] d1_q [3];
  logic bb1_q, bb2_q, bb3_q;
  logic [MW-1:0] rad1_q;
  logic [MW-1:0] sq_op [4];
  logic [PLW-1:0] pll2_q [4];
  logic [MW-1:0] plh2_q [4];
  logic [PUW-1:0] phh2_q [4];
  logic [SW-1:0] sq3_q [4];
  logic hit4_q;

  assign r4 = !v4_q || m_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign s_ready_o = r1;
  assign m_valid_o = v4_q;
  assign m_overlap_o = hit4_q;

  // three axis distances and the radius are squared the same way
  always_comb begin
    for (int i = 0; i < 3; i++) sq_op[i] = d1_q[i];
    sq_op[3] = rad1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= s_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && s_valid_i) begin
      logic bb;
      logic signed [DW-1:0] dd, lo, hi, q, p;
      bb = 1'b1;
      for (int i = 0; i < 3; i++) begin
        dd = DW'(s_box_c_i[i]) - DW'(s_oth_c_i[i]);
        if (dd < 0) dd = -dd;
        if (dd > DW'(s_box_h_i[i]) + DW'(s_oth_h_i[i])) bb = 1'b0;
        lo = DW'(s_box_c_i[i]) - DW'(s_box_h_i[i]);
        hi = DW'(s_box_c_i[i]) + DW'(s_box_h_i[i]);
        p = DW'(s_oth_c_i[i]);
        q = p > lo ? p : lo;
        q = q < hi ? q : hi;
        if (s_test_i == TEST_SS) q = DW'(s_box_c_i[i]);
        q = q - p;
        d1_q[i] <= q < 0 ? MW'(-q) : MW'(q);
      end
      bb1_q <= bb;
      t1_q <= s_test_i;
      rad1_q <= (s_test_i == TEST_SS) ? MW'(s_r0_i) + MW'(s_r1_i) : MW'(s_r1_i);
    end
    // split each square into half-width partial products
    if (r2 && v1_q) begin
      for (int k = 0; k < 4; k++) begin
        pll2_q[k] <= PLW'(sq_op[k][LW-1:0]) * PLW'(sq_op[k][LW-1:0]);
        plh2_q[k] <= MW'(sq_op[k][LW-1:0]) * MW'(sq_op[k][MW-1:LW]);
        phh2_q[k] <= PUW'(sq_op[k][MW-1:LW]) * PUW'(sq_op[k][MW-1:LW]);
      end
      bb2_q <= bb1_q;
      t2_q <= t1_q;
    end
    if (r3 && v2_q) begin
      for (int k = 0; k < 4; k++)
        sq3_q[k] <= (SW'(phh2_q[k]) << PLW) + (SW'(plh2_q[k]) << (LW + 1)) +
                    SW'(pll2_q[k]);
      bb3_q <= bb2_q;
      t3_q <= t2_q;
    end
    if (r4 && v3_q) begin
      case (t3_q)
        TEST_BB: hit4_q <= bb3_q;
        default: hit4_q <= (sq3_q[0] + sq3_q[1] + sq3_q[2]) <= sq3_q[3];
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/collider_pair_overlap_test.sv
// top level of the collider pair overlap test
// depends on cpot_pkg, cpot_front, cpot_queue, cpot_back
// One pair of colliders enters per cycle; the result leaves
// through a front register, a two-entry queue and a four-stage back
// pipeline (differences, partial products, squares, sum and compare).
// Sustained rate is one pair per cycle while the output side takes results.
`default_nettype none
module collider_pair_overlap_test import cpot_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 21,
  parameter int unsigned FRACTION_BITS  = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // a_kind, a_position, a_offset, a_scale, a_half_size, a_radius, then b likewise
  input  wire logic [2*(4*VEC_BITS+RAD_BITS+1)+6-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // overlap
  output logic [7:0] m_axis_tdata
);
  localparam int unsigned CW = COMPONENT_BITS + 1 + FRACTION_BITS;
  localparam int unsigned HW = 2 * COMPONENT_BITS + 1;
  localparam int unsigned RW = RAD_BITS + COMPONENT_BITS;
  localparam int unsigned QW = 2 + 6 * CW + 6 * HW + 2 * RW;
  localparam int unsigned BW = 4 * VEC_BITS + RAD_BITS + 1;

  logic f_valid, f_ready, b_valid, b_ready, ov;
  test_e f_test, b_test;
  logic signed [CW-1:0] fbc [3], foc [3], bbc [3], boc [3];
  logic signed [HW-1:0] fbh [3], foh [3], bbh [3], boh [3];
  logic [RW-1:0] fr0, fr1, br0, br1;
  logic [QW-1:0] q_in, q_out;

  cpot_front #(.CB(COMPONENT_BITS), .FB(FRACTION_BITS), .CW(CW), .HW(HW), .RW(RW))
  u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata[2*BW-1:0]), .f_valid_o(f_valid), .f_ready_i(f_ready),
    .f_test_o(f_test), .f_box_c_o(fbc), .f_box_h_o(fbh), .f_oth_c_o(foc),
    .f_oth_h_o(foh), .f_r0_o(fr0), .f_r1_o(fr1)
  );

  assign q_in = {f_test, fbc[0], fbc[1], fbc[2], foc[0], foc[1], foc[2],
                 fbh[0], fbh[1], fbh[2], foh[0], foh[1], foh[2], fr0, fr1};
  assign {b_test, bbc[0], bbc[1], bbc[2], boc[0], boc[1], boc[2],
          bbh[0], bbh[1], bbh[2], boh[0], boh[1], boh[2], br0, br1} = q_out;

  cpot_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni, .s_valid_i(f_valid), .s_ready_o(f_ready), .s_data_i(q_in),
    .m_valid_o(b_valid), .m_ready_i(b_ready), .m_data_o(q_out)
  );

  cpot_back #(.CB(COMPONENT_BITS), .FB(FRACTION_BITS), .CW(CW), .HW(HW), .RW(RW))
  u_back (
    .clk_i, .rst_ni, .s_valid_i(b_valid), .s_ready_o(b_ready), .s_test_i(b_test),
    .s_box_c_i(bbc), .s_box_h_i(bbh), .s_oth_c_i(boc), .s_oth_h_i(boh),
    .s_r0_i(br0), .s_r1_i(br1), .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready), .m_overlap_o(ov)
  );

  assign m_axis_tdata = {7'd0, ov};
endmodule
`default_nettype wire

// File: design/cpot_checker.sv
// port-level checks for the collider pair overlap test
// depends on collider_pair_overlap_test
`default_nettype none
module cpot_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("padding bits set");
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid || rst_ni)
    else $error("result valid during reset");
endmodule

bind collider_pair_overlap_test cpot_checker u_cpot_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
